>>> sv/lfr_pkg.sv
// Package for the length-prefixed frame receiver.
// Holds widths, codes, the item and stage structs and reset constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

  localparam int LFR_MAX_FRAME = 256;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 8;
  localparam int TICK_W        = 16;
  localparam int STATUS_W      = 3;

  localparam logic [IDX_W-1:0]  HDR_LAST      = 8'd3;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROGRESS = 3'd0,
    ST_OK       = 3'd1,
    ST_ABANDON  = 3'd2,
    ST_FRAMING  = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_SIZE     = 3'd5
  } status_t;

  typedef struct packed {
    req_t              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

`default_nettype wire

>>> sv/lfr_in_if.sv
// Request channel interface of the frame receiver: valid, ready and payload.
// Depends on lfr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lfr_in_if;
  import lfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> sv/lfr_out_if.sv
// Result channel interface of the frame receiver: valid, ready and payload.
// Depends on lfr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lfr_out_if;
  import lfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic [IDX_W-1:0]    byte_index;
  logic                has_byte;
  logic                frame_last;
  logic [STATUS_W-1:0] frame_status;

  modport source (output valid, output out_byte, output byte_index, output has_byte,
                  output frame_last, output frame_status, input ready);
  modport sink (input valid, input out_byte, input byte_index, input has_byte,
                input frame_last, input frame_status, output ready);
endinterface

`default_nettype wire

>>> sv/lfr_in_stage.sv
// Input register of the frame receiver: captures one request per cycle unless stalled.
// Depends on lfr_pkg and lfr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module lfr_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  lfr_in_if.sink               in_ch,
  output lfr_pkg::stage_t      s1,
  input  wire logic            s1_ready
);
  import lfr_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ch.ready = !valid_r || s1_ready;
  assign s1.valid    = valid_r;
  assign s1.item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item_r.req_type <= req_t'(in_ch.req_type);
      item_r.rx_byte  <= in_ch.rx_byte;
    end
  end

endmodule

`default_nettype wire

>>> sv/lfr_step.sv
// Frame state, per-request update logic and result register of the receiver.
// Depends on lfr_pkg and lfr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module lfr_step #(
  parameter int MAX_FRAME = lfr_pkg::LFR_MAX_FRAME
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lfr_pkg::stage_t             s1,
  output logic                             s1_ready,
  input  wire logic [lfr_pkg::TICK_W-1:0]  timeout,
  lfr_out_if.source                        out_ch
);
  import lfr_pkg::*;

  localparam int             LEN_W   = $clog2(MAX_FRAME - 3);
  localparam logic [IDX_W:0] LEN_MAX = (IDX_W + 1)'(MAX_FRAME - 4);

  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  body_r, body_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;

  logic                ovalid_r;
  logic [BYTE_W-1:0]   obyte_r, obyte_nxt;
  logic [IDX_W-1:0]    oidx_r, oidx_nxt;
  logic                ohas_r, ohas_nxt;
  logic                olast_r, olast_nxt;
  status_t             ostat_r, ostat_nxt;
  logic                res_v;

  logic                fire;
  logic [BYTE_W-1:0]   b;
  logic [IDX_W:0]      len9;
  logic [IDX_W:0]      end_idx;
  logic [TICK_W-1:0]   idle_inc;

  assign s1_ready = !ovalid_r || out_ch.ready;
  assign fire     = s1.valid && s1_ready;
  assign b        = s1.item.rx_byte;
  assign len9     = {1'b0, b} + (IDX_W + 1)'(1);
  assign end_idx  = {1'b0, HDR_LAST} + (IDX_W + 1)'(body_r);
  assign idle_inc = (idle_r == '1) ? idle_r : idle_r + TICK_W'(1);

  always_comb begin
    count_nxt = count_r;
    body_nxt  = body_r;
    xor_nxt   = xor_r;
    idle_nxt  = idle_r;
    res_v     = 1'b0;
    obyte_nxt = b;
    oidx_nxt  = count_r;
    ohas_nxt  = 1'b1;
    olast_nxt = 1'b0;
    ostat_nxt = ST_PROGRESS;
    case (s1.item.req_type)
      REQ_TICK: begin
        if (count_r != '0) begin
          if (idle_inc < timeout) begin
            idle_nxt = idle_inc;
          end else begin
            res_v     = 1'b1;
            obyte_nxt = '0;
            ohas_nxt  = 1'b0;
            olast_nxt = 1'b1;
            ostat_nxt = (count_r <= HDR_LAST) ? ST_ABANDON : ST_FRAMING;
            count_nxt = '0;
            body_nxt  = '0;
            xor_nxt   = '0;
            idle_nxt  = '0;
          end
        end
      end
      REQ_BYTE: begin
        res_v    = 1'b1;
        idle_nxt = '0;
        if (count_r <= HDR_LAST) begin
          if ((count_r == HDR_LAST) && (len9 > LEN_MAX)) begin
            olast_nxt = 1'b1;
            ostat_nxt = ST_SIZE;
            count_nxt = '0;
            body_nxt  = '0;
            xor_nxt   = '0;
          end else begin
            if (count_r == HDR_LAST) begin
              body_nxt = len9[LEN_W-1:0];
            end
            xor_nxt   = xor_r ^ b;
            count_nxt = count_r + IDX_W'(1);
          end
        end else if ({1'b0, count_r} >= end_idx) begin
          olast_nxt = 1'b1;
          ostat_nxt = (xor_r == b) ? ST_OK : ST_CHECKSUM;
          count_nxt = '0;
          body_nxt  = '0;
          xor_nxt   = '0;
        end else begin
          xor_nxt   = xor_r ^ b;
          count_nxt = count_r + IDX_W'(1);
        end
      end
      default: begin
        res_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      body_r   <= '0;
      xor_r    <= '0;
      idle_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
        body_r  <= body_nxt;
        xor_r   <= xor_nxt;
        idle_r  <= idle_nxt;
      end
      if (fire && res_v) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (fire && res_v) begin
      obyte_r <= obyte_nxt;
      oidx_r  <= oidx_nxt;
      ohas_r  <= ohas_nxt;
      olast_r <= olast_nxt;
      ostat_r <= ostat_nxt;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.out_byte     = obyte_r;
  assign out_ch.byte_index   = oidx_r;
  assign out_ch.has_byte     = ohas_r;
  assign out_ch.frame_last   = olast_r;
  assign out_ch.frame_status = ostat_r;

endmodule

`default_nettype wire

>>> sv/length_prefixed_frame_receiver.sv
// Top level of the length-prefixed frame receiver with XOR checksum.
// Depends on lfr_pkg, lfr_in_if, lfr_out_if, lfr_in_stage and lfr_step.
//
//   Channel  Direction  Contents
//   in_ch    sink       req_type (byte or tick), rx_byte
//   out_ch   source     out_byte, byte_index, has_byte, frame_last, frame_status
//   cfg_*    write      timeout_ticks (16 bits, no read-back)
//
// Each request passes an input register, the combinational frame logic and the
// result register, and a result is held there until out_ch takes it.
// One request is accepted every cycle while no result stalls; the rate is set by
// the single frame update. A stalled result holds the pipeline; ticks that give no
// result still wait for it. Reset is synchronous and active low; it empties the
// pipeline, clears the frame state and loads a timeout of 1000 ticks.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver #(
  parameter int MAX_FRAME = lfr_pkg::LFR_MAX_FRAME
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lfr_in_if.sink                           in_ch,
  lfr_out_if.source                        out_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lfr_pkg::TICK_W-1:0]  cfg_wr_data
);
  import lfr_pkg::*;

  logic [TICK_W-1:0] timeout_r;
  stage_t            s1;
  logic              s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  lfr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1       (s1),
    .s1_ready (s1_ready)
  );

  lfr_step #(
    .MAX_FRAME (MAX_FRAME)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1       (s1),
    .s1_ready (s1_ready),
    .timeout  (timeout_r),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1.valid && !s1_ready |=> s1.valid && $stable(s1.item))
    else $error("Input register lost or changed a stalled request.");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !s1.valid || s1_ready)
    else $error("Request taken while the input register was still occupied.");

  a_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1.valid && s1_ready && (s1.item.req_type == REQ_BYTE) |=>
      out_ch.valid && out_ch.has_byte)
    else $error("A received byte produced no result.");

  a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.has_byte |->
      out_ch.frame_last && (out_ch.out_byte == '0))
    else $error("Timeout result is not a zero byte ending the frame.");
`endif

endmodule

`default_nettype wire

>>> tb/tb_length_prefixed_frame_receiver.sv
// Self-checking testbench for length_prefixed_frame_receiver: it predicts every frame result
// from the requests it accepts and compares them field by field with what the block returns.
// Depends on lfr_pkg, lfr_in_if, lfr_out_if and the receiver RTL.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_receiver;
  import lfr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MODES = 4;
  localparam int IDLE_PCT[MODES] = '{0, 78, 0, 37};
  localparam int STALL_PCT[MODES] = '{0, 0, 78, 37};
  localparam logic [TICK_W-1:0] MIX_TIMEOUT[MODES] = '{16'd1, 16'd3, 16'd9, 16'd40};
  localparam logic [BYTE_W-1:0] OPENING[16] = '{
    8'h00, 8'hFF, 8'h55, 8'h00, 8'hAA,
    8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00,
    8'h12, 8'h34, 8'h56, 8'hFC,
    8'hAA
  };

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic              has;
    logic              last;
    status_t           status;
  } frame_result_t;

  class frame_tracker;
    logic [TICK_W-1:0] timeout_val = TIMEOUT_RESET;
    logic [IDX_W-1:0]  count = '0;
    logic [8:0]        body_len = '0;
    logic [BYTE_W-1:0] parity = '0;
    logic [TICK_W-1:0] idle = '0;
    frame_result_t     due_results[$];
    int                errors;
    int                checked;
    int                per_status[6];

    function void clear_frame();
      count = '0;
      body_len = '0;
      parity = '0;
      idle = '0;
    endfunction

    function void add(logic [BYTE_W-1:0] d, logic [IDX_W-1:0] i, logic h, logic l,
                      status_t s);
      frame_result_t r;
      r.data = d;
      r.index = i;
      r.has = h;
      r.last = l;
      r.status = s;
      due_results.push_back(r);
    endfunction

    function void note_request(req_t kind, logic [BYTE_W-1:0] b);
      logic [8:0] len;
      len = {1'b0, b} + 9'd1;
      if (kind == REQ_TICK) begin
        if (count == 0) return;
        if (idle != '1) idle = idle + 1'b1;
        if (idle < timeout_val) return;
        add('0, count, 1'b0, 1'b1, (count <= HDR_LAST) ? ST_ABANDON : ST_FRAMING);
        clear_frame();
      end else begin
        idle = '0;
        if (count == HDR_LAST && int'(len) > LFR_MAX_FRAME - 4) begin
          add(b, count, 1'b1, 1'b1, ST_SIZE);
          clear_frame();
        end else if (count > HDR_LAST && int'(count) >= int'(HDR_LAST) + int'(body_len)) begin
          add(b, count, 1'b1, 1'b1, (b == parity) ? ST_OK : ST_CHECKSUM);
          clear_frame();
        end else begin
          if (count == HDR_LAST) body_len = len;
          add(b, count, 1'b1, 1'b0, ST_PROGRESS);
          parity = parity ^ b;
          count = count + 1'b1;
        end
      end
    endfunction

    function void compare(string name, logic [15:0] exp_val, logic [15:0] got_val);
      if (exp_val !== got_val) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, got_val);
      end
    endfunction

    function void match_result(logic [BYTE_W-1:0] d, logic [IDX_W-1:0] i, logic h, logic l,
                               logic [STATUS_W-1:0] s);
      frame_result_t e;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual byte %0d index %0d status %0d",
                 $time, d, i, s);
        return;
      end
      e = due_results.pop_front();
      checked++;
      compare("out_byte", e.data, d);
      compare("byte_index", e.index, i);
      compare("has_byte", e.has, h);
      compare("frame_last", e.last, l);
      compare("frame_status", e.status, s);
      if (e.last) per_status[e.status]++;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en;
  logic [TICK_W-1:0] cfg_wr_data;
  logic [TICK_W-1:0] cur_timeout;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_left;
  int                cycles;
  int                n_items;
  frame_tracker      frames = new();

  lfr_in_if in_ch ();
  lfr_out_if out_ch ();

  length_prefixed_frame_receiver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               frames.due_results.size());
      $display("tb_length_prefixed_frame_receiver: FAIL");
      $finish;
    end else if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        frames.note_request(req_t'(in_ch.req_type), in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        frames.match_result(out_ch.out_byte, out_ch.byte_index, out_ch.has_byte,
                            out_ch.frame_last, out_ch.frame_status);
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic int tick_limit();
    return (cur_timeout == 0) ? 1 : int'(cur_timeout);
  endfunction

  task automatic send(req_t kind, logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send(REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(int len, bit bad, int cut);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] x;
    int                k;
    x = '0;
    for (int i = 0; i < len + 5; i++) begin
      if (i == cut) begin
        send_ticks(tick_limit());
        return;
      end
      if (i > 0 && cur_timeout > 1 && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, int'(cur_timeout) - 1);
        send_ticks(k);
      end
      if (i == 3) b = 8'(len);
      else if (i == len + 4) b = bad ? x ^ 8'($urandom_range(1, 255)) : x;
      else b = 8'($urandom_range(0, 255));
      send(REQ_BYTE, b);
      x = x ^ b;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_timeout(logic [TICK_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_timeout = v;
    frames.timeout_val = v;
  endtask

  task automatic run_mix(int count);
    int stop;
    int pick;
    int len;
    int k;
    stop = n_items + count;
    while (n_items < stop) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(13, 251) : $urandom_range(0, 12);
      if (pick < 65) begin
        send_frame(len, $urandom_range(0, 7) == 0, -1);
      end else if (pick < 75) begin
        send_frame(len, 1'b0, $urandom_range(1, len + 4));
      end else if (pick < 83) begin
        send_ticks(0);
        repeat (3) send(REQ_BYTE, 8'($urandom_range(0, 255)));
        send(REQ_BYTE, 8'($urandom_range(252, 255)));
      end else if (pick < 90) begin
        send_ticks($urandom_range(1, 4));
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) send(REQ_BYTE, 8'($urandom_range(0, 255)));
        send_ticks(tick_limit());
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    n_items = 0;
    cur_timeout = TIMEOUT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A good frame, a bad checksum and two oversized length bytes, behind an idle tick.
    send(REQ_TICK, 8'hFF);
    foreach (OPENING[i]) send(REQ_BYTE, OPENING[i]);
    send(REQ_BYTE, 8'hBB);
    send(REQ_BYTE, 8'hCC);
    send(REQ_BYTE, 8'hFF);

    set_timeout(16'd1);
    send_frame(3, 1'b0, 1);
    send_frame(3, 1'b0, 6);
    set_timeout(16'd0);
    send_frame(3, 1'b0, 2);
    set_timeout(16'hFFFF);
    send(REQ_BYTE, 8'h10);
    send_ticks(40);
    send(REQ_BYTE, 8'h20);
    send(REQ_BYTE, 8'h30);
    send(REQ_BYTE, 8'h00);
    send(REQ_BYTE, 8'h00);

    n_items = 0;
    for (int m = 0; m < MODES; m++) begin
      set_timeout(MIX_TIMEOUT[m]);
      send_idle_pct = IDLE_PCT[m];
      recv_stall_pct = STALL_PCT[m];
      run_mix(275);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_timeout(16'd5);
    hold_left = 400;
    send_frame(251, 1'b0, -1);
    run_mix(150);

    drain();
    $display("Checked %0d results from %0d counted requests: %0d ok, %0d checksum, %0d size,",
             frames.checked, n_items, frames.per_status[ST_OK],
             frames.per_status[ST_CHECKSUM], frames.per_status[ST_SIZE]);
    $display("%0d abandoned, %0d framing; timeouts 0, 1, 65535 and mixed handshakes.",
             frames.per_status[ST_ABANDON], frames.per_status[ST_FRAMING]);
    if (frames.errors == 0 && frames.due_results.size() == 0) begin
      $display("tb_length_prefixed_frame_receiver: PASS");
    end else begin
      $display("tb_length_prefixed_frame_receiver: FAIL");
    end
    $finish;
  end

endmodule

>>> length_prefixed_frame_receiver.f
sv/lfr_pkg.sv
sv/lfr_in_if.sv
sv/lfr_out_if.sv
sv/lfr_in_stage.sv
sv/lfr_step.sv
sv/length_prefixed_frame_receiver.sv
tb/tb_length_prefixed_frame_receiver.sv
